/* hdl/pbc_pkg.sv */
// ----------------------------------------------------------------------------
// pbc_pkg: shared definitions of the pileup base counter
// Character codes, base codes, strand group codes, field widths, the decoder that
// turns an upper-case letter into a base index and a lower-to-upper case converter.
// ----------------------------------------------------------------------------
package pbc_pkg;

	localparam int BASE_NUM    = 5;
	localparam int BASE_W      = 3;
	localparam int SKIP_W      = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam int IN_TDATA_W  = 16;
	localparam int OUT_CNT_W   = 17;
	localparam int OUT_SUM_W   = 20;
	localparam int OUT_TDATA_W = 128;
	localparam int GROUP_W     = 2;

	localparam logic [BASE_W-1:0] BASE_A    = 3'd0;
	localparam logic [BASE_W-1:0] BASE_C    = 3'd1;
	localparam logic [BASE_W-1:0] BASE_G    = 3'd2;
	localparam logic [BASE_W-1:0] BASE_T    = 3'd3;
	localparam logic [BASE_W-1:0] BASE_N    = 3'd4;
	localparam logic [BASE_W-1:0] BASE_NONE = 3'd7;

	localparam logic [GROUP_W-1:0] GRP_BOTH    = 2'd0;
	localparam logic [GROUP_W-1:0] GRP_FORWARD = 2'd1;
	localparam logic [GROUP_W-1:0] GRP_REVERSE = 2'd2;

	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_CARET   = 8'h5E;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_DIFF  = 8'h20;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic [BASE_W-1:0] base_of(input logic [7:0] ch);
		logic [BASE_W-1:0] b;
		unique case (ch)
			8'h41:   b = BASE_A;
			8'h43:   b = BASE_C;
			8'h47:   b = BASE_G;
			8'h54:   b = BASE_T;
			8'h4E:   b = BASE_N;
			default: b = BASE_NONE;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] ch);
		logic [7:0] r;
		r = ch;
		if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
			r = ch - CASE_DIFF;
		end
		return r;
	endfunction

endpackage

/* hdl/pbc_front.sv */
// ----------------------------------------------------------------------------
// pbc_front: character parser and strand counters
// Accepts one character per transaction, tracks the reference base and the
// indel/skip parser, and keeps saturating counters per base and strand. At
// the end of a position it pushes a snapshot of the counters into the queue.
// ----------------------------------------------------------------------------
module pbc_front import pbc_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	input  logic [IN_TDATA_W-1:0]                    s_tdata,
	input  logic                                     s_tuser,
	input  logic                                     s_tlast,
	input  fifo_stat_t                               q_stat,
	output logic                                     push,
	output logic [BASE_NUM-1:0][COUNT_WIDTH-1:0]     snap_fwd,
	output logic [BASE_NUM-1:0][COUNT_WIDTH-1:0]     snap_rev,
	output logic [BASE_W-1:0]                        snap_ref
);

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_SKIP1,
		MODE_LEN,
		MODE_SKIPN
	} mode_t;

	localparam int MUL_W = SKIP_W + 4;

	logic [BASE_NUM-1:0][COUNT_WIDTH-1:0] fwd_q, rev_q, fwd_nx, rev_nx;
	logic [BASE_W-1:0]  ref_q, ref_now, ref_dec;
	logic [SKIP_W-1:0]  skip_q, skip_d;
	mode_t              mode_q, mode_d;
	logic [7:0]         pc, rc;
	logic               accept, is_digit, do_normal;
	logic [MUL_W-1:0]   skip_x10;
	logic [BASE_W-1:0]  fwd_idx, rev_idx, pc_base_up, pc_base_lo;

	assign pc       = s_tdata[7:0];
	assign rc       = s_tdata[15:8];
	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;

	// The reference letter is decoded before the pileup character is handled.
	assign ref_dec = base_of(to_upper(rc));
	assign ref_now = (ref_dec != BASE_NONE) ? ref_dec : ref_q;

	assign is_digit   = (pc >= CH_ZERO) && (pc <= CH_NINE);
	assign skip_x10   = ({4'b0, skip_q} << 3) + ({4'b0, skip_q} << 1)
	                    + MUL_W'(pc - CH_ZERO);
	assign pc_base_up = base_of(pc);
	assign pc_base_lo = (pc >= CH_LOWER_A && pc <= CH_LOWER_Z) ?
	                    base_of(pc - CASE_DIFF) : BASE_NONE;

	always_comb begin
		fwd_idx   = BASE_NONE;
		rev_idx   = BASE_NONE;
		mode_d    = mode_q;
		skip_d    = skip_q;
		do_normal = 1'b0;
		if (s_tuser) begin
			unique case (mode_q)
				MODE_SKIP1: begin
					mode_d = MODE_NORMAL;
				end
				MODE_LEN: begin
					if (is_digit) begin
						skip_d = (skip_x10 > MUL_W'({SKIP_W{1'b1}})) ?
						         {SKIP_W{1'b1}} : skip_x10[SKIP_W-1:0];
					end else if (skip_q == '0) begin
						// An indel without a length: this character is parsed normally.
						mode_d    = MODE_NORMAL;
						do_normal = 1'b1;
					end else begin
						skip_d = skip_q - 1'b1;
						mode_d = (skip_q != SKIP_W'(1)) ? MODE_SKIPN : MODE_NORMAL;
					end
				end
				MODE_SKIPN: begin
					if (skip_q != '0) begin
						skip_d = skip_q - 1'b1;
					end
					if (skip_q <= SKIP_W'(1)) begin
						mode_d = MODE_NORMAL;
					end
				end
				MODE_NORMAL: begin
					do_normal = 1'b1;
				end
				default: begin
					mode_d = MODE_NORMAL;
				end
			endcase
		end
		if (do_normal) begin
			priority if (pc == CH_DOT) begin
				fwd_idx = ref_now;
			end else if (pc == CH_COMMA) begin
				rev_idx = ref_now;
			end else if (pc == CH_CARET) begin
				mode_d = MODE_SKIP1;
			end else if (pc == CH_PLUS || pc == CH_MINUS) begin
				mode_d = MODE_LEN;
				skip_d = '0;
			end else if (pc_base_up != BASE_NONE) begin
				fwd_idx = pc_base_up;
			end else begin
				rev_idx = pc_base_lo;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < BASE_NUM; i++) begin
			fwd_nx[i] = fwd_q[i];
			rev_nx[i] = rev_q[i];
			if (fwd_idx == BASE_W'(i) && fwd_q[i] != {COUNT_WIDTH{1'b1}}) begin
				fwd_nx[i] = fwd_q[i] + 1'b1;
			end
			if (rev_idx == BASE_W'(i) && rev_q[i] != {COUNT_WIDTH{1'b1}}) begin
				rev_nx[i] = rev_q[i] + 1'b1;
			end
		end
	end

	assign push     = accept && s_tlast;
	assign snap_fwd = fwd_nx;
	assign snap_rev = rev_nx;
	assign snap_ref = ref_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q  <= '0;
			rev_q  <= '0;
			ref_q  <= BASE_A;
			mode_q <= MODE_NORMAL;
			skip_q <= '0;
		end else if (accept) begin
			ref_q <= ref_now;
			if (s_tlast) begin
				fwd_q  <= '0;
				rev_q  <= '0;
				mode_q <= MODE_NORMAL;
				skip_q <= '0;
			end else begin
				fwd_q  <= fwd_nx;
				rev_q  <= rev_nx;
				mode_q <= mode_d;
				skip_q <= skip_d;
			end
		end
	end

endmodule

/* hdl/pbc_queue.sv */
// ----------------------------------------------------------------------------
// pbc_queue: snapshot queue between parser and result generator
// A small register FIFO of counter snapshots so the parser keeps taking
// characters while the result side is still busy with an earlier position.
// ----------------------------------------------------------------------------
module pbc_queue import pbc_pkg::*; #(
	parameter int DATA_W = 163
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              pop,
	output logic [DATA_W-1:0] rd_data,
	output fifo_stat_t        stat
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
	logic [AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [AW:0]       count_q;

	assign stat.full  = (count_q == (AW+1)'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign rd_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/pbc_back.sv */
// ----------------------------------------------------------------------------
// pbc_back: result generator
// Turns each counter snapshot into three results (both strands, forward,
// reverse). Stage one selects the group counts, stage two forms the sum,
// the reference match and the majority base into the output register.
// ----------------------------------------------------------------------------
module pbc_back import pbc_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fifo_stat_t                           q_stat,
	input  logic [BASE_NUM-1:0][COUNT_WIDTH-1:0] q_fwd,
	input  logic [BASE_NUM-1:0][COUNT_WIDTH-1:0] q_rev,
	input  logic [BASE_W-1:0]                    q_ref,
	output logic                                 pop,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [OUT_TDATA_W-1:0]               m_tdata,
	output logic [GROUP_W-1:0]                   m_tuser,
	output logic                                 m_tlast
);

	localparam int TW = COUNT_WIDTH + 1;
	localparam int SW = COUNT_WIDTH + 4;

	logic [GROUP_W-1:0]              grp_q;
	logic                            valid_s1;
	logic [BASE_NUM-1:0][TW-1:0]     cnt_s1;
	logic [GROUP_W-1:0]              grp_s1;
	logic [BASE_W-1:0]               ref_s1;
	logic                            load_s1, load_s2;
	logic [BASE_NUM-1:0][TW-1:0]     sel;
	logic [SW-1:0]                   sum;
	logic [TW-1:0]                   best;
	logic [BASE_W-1:0]               maj;
	logic [BASE_NUM-1:0][OUT_CNT_W-1:0] cnt_out;
	logic [TW+OUT_CNT_W-1:0]         ext_tmp [BASE_NUM];
	logic [TW+OUT_CNT_W-1:0]         ref_tmp;
	logic [SW+OUT_SUM_W-1:0]         sum_tmp;

	assign load_s2 = valid_s1 && (!m_tvalid || m_tready);
	assign load_s1 = !q_stat.empty && (!valid_s1 || load_s2);
	assign pop     = load_s1 && (grp_q == GRP_REVERSE);

	always_comb begin
		for (int i = 0; i < BASE_NUM; i++) begin
			unique case (grp_q)
				GRP_FORWARD: sel[i] = {1'b0, q_fwd[i]};
				GRP_REVERSE: sel[i] = {1'b0, q_rev[i]};
				default:     sel[i] = {1'b0, q_fwd[i]} + {1'b0, q_rev[i]};
			endcase
		end
	end

	// Ties keep the lower base index; all zero counts give base A.
	always_comb begin
		sum  = '0;
		best = '0;
		maj  = BASE_A;
		for (int i = 0; i < BASE_NUM; i++) begin
			sum = sum + SW'(cnt_s1[i]);
			if (cnt_s1[i] > best) begin
				best = cnt_s1[i];
				maj  = BASE_W'(i);
			end
			ext_tmp[i] = {{OUT_CNT_W{1'b0}}, cnt_s1[i]};
			cnt_out[i] = ext_tmp[i][OUT_CNT_W-1:0];
		end
		ref_tmp = {{OUT_CNT_W{1'b0}}, cnt_s1[ref_s1]};
		sum_tmp = {{OUT_SUM_W{1'b0}}, sum};
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			cnt_s1 <= sel;
			grp_s1 <= grp_q;
			ref_s1 <= q_ref;
		end
		if (load_s2) begin
			m_tdata <= {ref_s1, maj, ref_tmp[OUT_CNT_W-1:0],
			            sum_tmp[OUT_SUM_W-1:0],
			            cnt_out[4], cnt_out[3], cnt_out[2], cnt_out[1], cnt_out[0]};
			m_tuser <= grp_s1;
			m_tlast <= (grp_s1 == GRP_REVERSE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q    <= GRP_BOTH;
			valid_s1 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (load_s1) begin
				grp_q <= (grp_q == GRP_REVERSE) ? GRP_BOTH : grp_q + 1'b1;
			end
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (load_s2) begin
				valid_s1 <= 1'b0;
			end
			if (load_s2) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

endmodule

/* hdl/pileup_base_counter_core.sv */
// The first of three results for a position passes through the snapshot queue,
// the stage-one register and the output register; forward and reverse follow one
// per cycle while the sink takes them. Throughput: one character per cycle while
// the two-entry snapshot queue has room; each position end yields three results.
// Reset (arst_n low, asynchronous): counters and parser cleared, reference
// base set to A, queue emptied and no result valid.
// ----------------------------------------------------------------------------
// pileup_base_counter_core: pileup base counter top level
// Counts bases per strand from a pileup character stream and reports the
// both-strand, forward and reverse totals at the end of each position.
// ----------------------------------------------------------------------------
module pileup_base_counter_core import pbc_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // pile_char[7:0], ref_char[15:8]
	input  logic                   s_tuser,   // has_char[0]
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // count_a[16:0], count_c[33:17],
	                                          // count_g[50:34], count_t[67:51],
	                                          // count_n[84:68], depth_sum[104:85],
	                                          // ref_match[121:105],
	                                          // majority_base[124:122],
	                                          // reference_base[127:125]
	output logic [GROUP_W-1:0]     m_tuser,   // strand_group[1:0]
	output logic                   m_tlast
);

	localparam int CNT_BITS = BASE_NUM * COUNT_WIDTH;
	localparam int DATA_W   = 2 * CNT_BITS + BASE_W;

	fifo_stat_t                           q_stat;
	logic                                 push, pop;
	logic [BASE_NUM-1:0][COUNT_WIDTH-1:0] snap_fwd, snap_rev, q_fwd, q_rev;
	logic [BASE_W-1:0]                    snap_ref, q_ref;
	logic [DATA_W-1:0]                    rd_data;

	pbc_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.q_stat   (q_stat),
		.push     (push),
		.snap_fwd (snap_fwd),
		.snap_rev (snap_rev),
		.snap_ref (snap_ref)
	);

	pbc_queue #(.DATA_W(DATA_W)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data ({snap_ref, snap_rev, snap_fwd}),
		.pop     (pop),
		.rd_data (rd_data),
		.stat    (q_stat)
	);

	assign q_fwd = rd_data[CNT_BITS-1:0];
	assign q_rev = rd_data[2*CNT_BITS-1:CNT_BITS];
	assign q_ref = rd_data[DATA_W-1:2*CNT_BITS];

	pbc_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.q_fwd    (q_fwd),
		.q_rev    (q_rev),
		.q_ref    (q_ref),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

/* hdl/pbc_checker.sv */
// ----------------------------------------------------------------------------
// pbc_checker: port-level checks of the pileup base counter
// Watches the result stream for group order, marker consistency, legal
// base codes and a held transaction while the sink stalls.
// ----------------------------------------------------------------------------
module pbc_checker import pbc_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic [GROUP_W-1:0]     m_tuser,
	input logic                   m_tlast
);

	logic [GROUP_W-1:0] exp_grp_q;

	// Results come strictly as both, forward, reverse for every position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_grp_q <= GRP_BOTH;
		end else if (m_tvalid && m_tready) begin
			exp_grp_q <= (m_tuser == GRP_REVERSE) ? GRP_BOTH : m_tuser + 1'b1;
		end
	end

	a_group_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == exp_grp_q))
		else $error("strand group out of order");

	a_last_marks_reverse: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == GRP_REVERSE)))
		else $error("tlast does not match the reverse group");

	a_base_codes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[124:122] <= BASE_N) && (m_tdata[127:125] <= BASE_N))
		else $error("base code out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

endmodule

bind pileup_base_counter_core pbc_checker u_pbc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
